FILE: hdl/wtsc_pkg.sv
// Shared types, codes and helpers for the weekly time switch controller.
// Used by wtsc_engine and weekly_time_switch_controller_core; depends on nothing.
package wtsc_pkg;

  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned DATE_W   = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 7;
  localparam int unsigned WDAY_W   = 3;
  localparam int unsigned FIELD_W  = 7;
  localparam int unsigned TIME_W   = 6;

  localparam logic [FIELD_W-1:0] HOUR_TOP   = 7'd23;
  localparam logic [FIELD_W-1:0] MINUTE_TOP = 7'd59;
  localparam logic [FIELD_W-1:0] DATE_TOP   = 7'd31;
  localparam logic [FIELD_W-1:0] MONTH_TOP  = 7'd12;
  localparam logic [FIELD_W-1:0] YEAR_TOP   = 7'd30;
  localparam logic [FIELD_W-1:0] WDAY_TOP   = 7'd6;
  localparam logic [FIELD_W-1:0] BOTTOM_0   = 7'd0;
  localparam logic [FIELD_W-1:0] BOTTOM_1   = 7'd1;
  localparam logic [2:0]         CURSOR_TOP = 3'd6;

  // Item kinds.
  localparam logic KIND_BUTTON = 1'b0;
  localparam logic KIND_CLOCK  = 1'b1;

  // Button codes; their meaning depends on the menu state.
  typedef enum logic [1:0] {
    BTN_SELECT = 2'd0,
    BTN_NEXT   = 2'd1,
    BTN_INC    = 2'd2,
    BTN_BACK   = 2'd3
  } button_t;

  // Menu states, one-hot.
  typedef enum logic [4:0] {
    MENU_IDLE  = 5'b00001,
    MENU_MAIN  = 5'b00010,
    MENU_CLOCK = 5'b00100,
    MENU_TIMES = 5'b01000,
    MENU_DAYS  = 5'b10000
  } menu_t;

  // Encoded menu state as reported on the result channel.
  localparam logic [2:0] CODE_IDLE  = 3'd0;
  localparam logic [2:0] CODE_MAIN  = 3'd1;
  localparam logic [2:0] CODE_CLOCK = 3'd2;
  localparam logic [2:0] CODE_TIMES = 3'd3;
  localparam logic [2:0] CODE_DAYS  = 3'd4;

  // Clock cursor positions in the clock editor.
  localparam logic [2:0] CUR_HOUR   = 3'd0;
  localparam logic [2:0] CUR_MINUTE = 3'd1;
  localparam logic [2:0] CUR_SECOND = 3'd2;
  localparam logic [2:0] CUR_DATE   = 3'd3;
  localparam logic [2:0] CUR_MONTH  = 3'd4;
  localparam logic [2:0] CUR_YEAR   = 3'd5;
  localparam logic [2:0] CUR_WDAY   = 3'd6;

  typedef struct packed {
    logic                kind;
    logic [1:0]          button;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [DATE_W-1:0]   date;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [WDAY_W-1:0]   weekday;
  } item_t;

  typedef struct packed {
    logic [1:0]          relay_bits;
    logic [2:0]          menu_state;
    logic                week_mode;
    logic [2:0]          cursor_index;
    logic                clock_write;
    logic [HOUR_W-1:0]   set_hour;
    logic [MINUTE_W-1:0] set_minute;
    logic [SECOND_W-1:0] set_second;
    logic [DATE_W-1:0]   set_date;
    logic [MONTH_W-1:0]  set_month;
    logic [YEAR_W-1:0]   set_year;
    logic [WDAY_W-1:0]   set_weekday;
  } result_t;

  function automatic logic [FIELD_W-1:0] wrap_inc(input logic [FIELD_W-1:0] v,
                                                  input logic [FIELD_W-1:0] top,
                                                  input logic [FIELD_W-1:0] bottom);
    return (v >= top) ? bottom : FIELD_W'(v + 1'b1);
  endfunction

  function automatic logic [2:0] menu_code(input menu_t m);
    logic [2:0] c;
    case (m)
      MENU_MAIN:  c = CODE_MAIN;
      MENU_CLOCK: c = CODE_CLOCK;
      MENU_TIMES: c = CODE_TIMES;
      MENU_DAYS:  c = CODE_DAYS;
      default:    c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/wtsc_engine.sv
// Menu machine, clock and schedule editors, relay control and weekly schedule.
// Holds all controller state; updates it for one item per step. Uses wtsc_pkg.
module wtsc_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  wtsc_pkg::item_t   item,
  output wtsc_pkg::result_t res
);

  wtsc_pkg::menu_t menu_r, menu_nxt;
  logic        sched_mode_r, sched_mode_nxt;
  logic [1:0]  wanted_r, wanted_nxt;
  logic [1:0]  drive_r, drive_nxt;
  logic        sched_on_r, sched_on_nxt;
  logic        sched_ready_r, sched_ready_nxt;

  logic [wtsc_pkg::HOUR_W-1:0]   now_hour_r, now_hour_nxt;
  logic [wtsc_pkg::MINUTE_W-1:0] now_minute_r, now_minute_nxt;
  logic [wtsc_pkg::SECOND_W-1:0] now_second_r, now_second_nxt;
  logic [wtsc_pkg::DATE_W-1:0]   now_date_r, now_date_nxt;
  logic [wtsc_pkg::MONTH_W-1:0]  now_month_r, now_month_nxt;
  logic [wtsc_pkg::YEAR_W-1:0]   now_year_r, now_year_nxt;
  logic [wtsc_pkg::WDAY_W-1:0]   now_wday_r, now_wday_nxt;

  logic [wtsc_pkg::HOUR_W-1:0]   ed_hour_r, ed_hour_nxt;
  logic [wtsc_pkg::MINUTE_W-1:0] ed_minute_r, ed_minute_nxt;
  logic [wtsc_pkg::SECOND_W-1:0] ed_second_r, ed_second_nxt;
  logic [wtsc_pkg::DATE_W-1:0]   ed_date_r, ed_date_nxt;
  logic [wtsc_pkg::MONTH_W-1:0]  ed_month_r, ed_month_nxt;
  logic [wtsc_pkg::YEAR_W-1:0]   ed_year_r, ed_year_nxt;
  logic [wtsc_pkg::WDAY_W-1:0]   ed_wday_r, ed_wday_nxt;

  logic [2:0] clk_cur_r, clk_cur_nxt;
  logic [1:0] week_cur_r, week_cur_nxt;
  logic [2:0] day_cur_r, day_cur_nxt;
  logic [wtsc_pkg::TIME_W-1:0] wt_r [4];
  logic [wtsc_pkg::TIME_W-1:0] wt_nxt [4];
  logic [6:0] marks_r, marks_nxt;

  logic        write;
  logic        sched_ready_mid;
  logic        sched_on_mid;
  logic        day_hit;
  logic [11:0] now_t, on_t, off_t;
  logic [1:0]  mask;
  logic [wtsc_pkg::FIELD_W-1:0] top;

  always_comb begin
    menu_nxt       = menu_r;
    sched_mode_nxt = sched_mode_r;
    wanted_nxt     = wanted_r;
    drive_nxt      = drive_r;
    now_hour_nxt   = now_hour_r;
    now_minute_nxt = now_minute_r;
    now_second_nxt = now_second_r;
    now_date_nxt   = now_date_r;
    now_month_nxt  = now_month_r;
    now_year_nxt   = now_year_r;
    now_wday_nxt   = now_wday_r;
    ed_hour_nxt    = ed_hour_r;
    ed_minute_nxt  = ed_minute_r;
    ed_second_nxt  = ed_second_r;
    ed_date_nxt    = ed_date_r;
    ed_month_nxt   = ed_month_r;
    ed_year_nxt    = ed_year_r;
    ed_wday_nxt    = ed_wday_r;
    clk_cur_nxt    = clk_cur_r;
    week_cur_nxt   = week_cur_r;
    day_cur_nxt    = day_cur_r;
    wt_nxt         = wt_r;
    marks_nxt      = marks_r;
    write          = 1'b0;
    mask           = 2'b00;
    top            = week_cur_r[0] ? wtsc_pkg::MINUTE_TOP : wtsc_pkg::HOUR_TOP;

    if (item.kind == wtsc_pkg::KIND_CLOCK) begin
      // The time is only latched while idle.
      if (menu_r == wtsc_pkg::MENU_IDLE) begin
        now_hour_nxt   = item.hour;
        now_minute_nxt = item.minute;
        now_second_nxt = item.second;
        now_date_nxt   = item.date;
        now_month_nxt  = item.month;
        now_year_nxt   = item.year;
        now_wday_nxt   = item.weekday;
      end
    end else begin
      case (menu_r)
        wtsc_pkg::MENU_MAIN: begin
          case (wtsc_pkg::button_t'(item.button))
            wtsc_pkg::BTN_SELECT: menu_nxt = wtsc_pkg::MENU_IDLE;
            wtsc_pkg::BTN_NEXT: begin
              ed_hour_nxt   = now_hour_r;
              ed_minute_nxt = now_minute_r;
              ed_second_nxt = now_second_r;
              ed_date_nxt   = now_date_r;
              ed_month_nxt  = now_month_r;
              ed_year_nxt   = now_year_r;
              ed_wday_nxt   = now_wday_r;
              menu_nxt      = wtsc_pkg::MENU_CLOCK;
            end
            wtsc_pkg::BTN_INC: menu_nxt = wtsc_pkg::MENU_TIMES;
            default: begin
              sched_mode_nxt = 1'b0;
              menu_nxt       = wtsc_pkg::MENU_IDLE;
            end
          endcase
        end
        wtsc_pkg::MENU_CLOCK: begin
          case (wtsc_pkg::button_t'(item.button))
            wtsc_pkg::BTN_SELECT: begin
              write       = 1'b1;
              menu_nxt    = wtsc_pkg::MENU_IDLE;
              clk_cur_nxt = '0;
            end
            wtsc_pkg::BTN_NEXT:
              clk_cur_nxt = (clk_cur_r >= wtsc_pkg::CURSOR_TOP) ? 3'd0 : 3'(clk_cur_r + 1'b1);
            wtsc_pkg::BTN_INC: begin
              case (clk_cur_r)
                wtsc_pkg::CUR_HOUR: ed_hour_nxt = wtsc_pkg::HOUR_W'(wtsc_pkg::wrap_inc(
                  7'(ed_hour_r), wtsc_pkg::HOUR_TOP, wtsc_pkg::BOTTOM_0));
                wtsc_pkg::CUR_MINUTE: ed_minute_nxt = wtsc_pkg::MINUTE_W'(wtsc_pkg::wrap_inc(
                  7'(ed_minute_r), wtsc_pkg::MINUTE_TOP, wtsc_pkg::BOTTOM_0));
                wtsc_pkg::CUR_SECOND: ed_second_nxt = wtsc_pkg::SECOND_W'(wtsc_pkg::wrap_inc(
                  7'(ed_second_r), wtsc_pkg::MINUTE_TOP, wtsc_pkg::BOTTOM_0));
                wtsc_pkg::CUR_DATE: ed_date_nxt = wtsc_pkg::DATE_W'(wtsc_pkg::wrap_inc(
                  7'(ed_date_r), wtsc_pkg::DATE_TOP, wtsc_pkg::BOTTOM_1));
                wtsc_pkg::CUR_MONTH: ed_month_nxt = wtsc_pkg::MONTH_W'(wtsc_pkg::wrap_inc(
                  7'(ed_month_r), wtsc_pkg::MONTH_TOP, wtsc_pkg::BOTTOM_1));
                wtsc_pkg::CUR_YEAR: ed_year_nxt = wtsc_pkg::YEAR_W'(wtsc_pkg::wrap_inc(
                  7'(ed_year_r), wtsc_pkg::YEAR_TOP, wtsc_pkg::BOTTOM_0));
                wtsc_pkg::CUR_WDAY: ed_wday_nxt = wtsc_pkg::WDAY_W'(wtsc_pkg::wrap_inc(
                  7'(ed_wday_r), wtsc_pkg::WDAY_TOP, wtsc_pkg::BOTTOM_0));
                default: ;
              endcase
            end
            default: begin
              menu_nxt    = wtsc_pkg::MENU_MAIN;
              clk_cur_nxt = '0;
            end
          endcase
        end
        wtsc_pkg::MENU_TIMES: begin
          case (wtsc_pkg::button_t'(item.button))
            wtsc_pkg::BTN_SELECT: menu_nxt = wtsc_pkg::MENU_DAYS;
            wtsc_pkg::BTN_NEXT:   week_cur_nxt = 2'(week_cur_r + 1'b1);
            wtsc_pkg::BTN_INC:
              wt_nxt[week_cur_r] = wtsc_pkg::TIME_W'(wtsc_pkg::wrap_inc(
                7'(wt_r[week_cur_r]), top, wtsc_pkg::BOTTOM_0));
            default: begin
              for (int i = 0; i < 4; i++) wt_nxt[i] = '0;
              menu_nxt = wtsc_pkg::MENU_MAIN;
            end
          endcase
        end
        wtsc_pkg::MENU_DAYS: begin
          case (wtsc_pkg::button_t'(item.button))
            wtsc_pkg::BTN_SELECT: begin
              sched_mode_nxt = 1'b1;
              menu_nxt       = wtsc_pkg::MENU_IDLE;
            end
            wtsc_pkg::BTN_NEXT:
              day_cur_nxt = (day_cur_r >= wtsc_pkg::CURSOR_TOP) ? 3'd0 : 3'(day_cur_r + 1'b1);
            wtsc_pkg::BTN_INC: marks_nxt = marks_r ^ (7'd1 << day_cur_r);
            default: begin
              marks_nxt      = '0;
              sched_mode_nxt = 1'b0;
              menu_nxt       = wtsc_pkg::MENU_TIMES;
            end
          endcase
        end
        default: begin
          menu_nxt = wtsc_pkg::MENU_IDLE;
          case (wtsc_pkg::button_t'(item.button))
            wtsc_pkg::BTN_SELECT: menu_nxt = wtsc_pkg::MENU_MAIN;
            wtsc_pkg::BTN_NEXT:   mask = 2'b01;
            wtsc_pkg::BTN_INC:    mask = 2'b10;
            default:              mask = 2'b11;
          endcase
          // A toggle drives the toggled relays from the new wishes.
          wanted_nxt = wanted_r ^ mask;
          drive_nxt  = (drive_r & ~mask) | (wanted_nxt & mask);
        end
      endcase
    end
  end

  // Weekly schedule: switch on at or after the on time, then off at or after the
  // off time, both checked in the same step.
  always_comb begin
    now_t   = {1'b0, now_hour_nxt, now_minute_nxt};
    on_t    = {wt_nxt[0], wt_nxt[1]};
    off_t   = {wt_nxt[2], wt_nxt[3]};
    day_hit = (now_wday_nxt <= 3'd6) && marks_nxt[now_wday_nxt];
    sched_on_mid    = sched_on_r;
    sched_ready_mid = sched_ready_r;
    if (sched_mode_nxt && day_hit && (now_t >= on_t) && sched_ready_r) begin
      sched_on_mid    = 1'b1;
      sched_ready_mid = 1'b0;
    end
    sched_on_nxt    = sched_on_mid;
    sched_ready_nxt = sched_ready_mid;
    if (sched_mode_nxt && day_hit && (now_t >= off_t) && !sched_ready_mid) begin
      sched_on_nxt    = 1'b0;
      sched_ready_nxt = 1'b1;
    end
  end

  always_comb begin
    res              = '0;
    res.relay_bits   = sched_mode_nxt ? {2{sched_on_nxt}} : drive_nxt;
    res.menu_state   = wtsc_pkg::menu_code(menu_nxt);
    res.week_mode    = sched_mode_nxt;
    case (menu_nxt)
      wtsc_pkg::MENU_CLOCK: res.cursor_index = clk_cur_nxt;
      wtsc_pkg::MENU_TIMES: res.cursor_index = {1'b0, week_cur_nxt};
      wtsc_pkg::MENU_DAYS:  res.cursor_index = day_cur_nxt;
      default:              res.cursor_index = '0;
    endcase
    res.clock_write = write;
    if (write) begin
      res.set_hour    = ed_hour_nxt;
      res.set_minute  = ed_minute_nxt;
      res.set_second  = ed_second_nxt;
      res.set_date    = ed_date_nxt;
      res.set_month   = ed_month_nxt;
      res.set_year    = ed_year_nxt;
      res.set_weekday = ed_wday_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_r        <= wtsc_pkg::MENU_IDLE;
      sched_mode_r  <= 1'b0;
      wanted_r      <= '0;
      drive_r       <= '0;
      sched_on_r    <= 1'b0;
      sched_ready_r <= 1'b1;
      now_hour_r    <= '0;
      now_minute_r  <= '0;
      now_second_r  <= '0;
      now_date_r    <= '0;
      now_month_r   <= '0;
      now_year_r    <= '0;
      now_wday_r    <= '0;
      ed_hour_r     <= '0;
      ed_minute_r   <= '0;
      ed_second_r   <= '0;
      ed_date_r     <= '0;
      ed_month_r    <= '0;
      ed_year_r     <= '0;
      ed_wday_r     <= '0;
      clk_cur_r     <= '0;
      week_cur_r    <= '0;
      day_cur_r     <= '0;
      for (int i = 0; i < 4; i++) wt_r[i] <= '0;
      marks_r       <= '0;
    end else if (step) begin
      menu_r        <= menu_nxt;
      sched_mode_r  <= sched_mode_nxt;
      wanted_r      <= wanted_nxt;
      drive_r       <= res.relay_bits;
      sched_on_r    <= sched_on_nxt;
      sched_ready_r <= sched_ready_nxt;
      now_hour_r    <= now_hour_nxt;
      now_minute_r  <= now_minute_nxt;
      now_second_r  <= now_second_nxt;
      now_date_r    <= now_date_nxt;
      now_month_r   <= now_month_nxt;
      now_year_r    <= now_year_nxt;
      now_wday_r    <= now_wday_nxt;
      ed_hour_r     <= ed_hour_nxt;
      ed_minute_r   <= ed_minute_nxt;
      ed_second_r   <= ed_second_nxt;
      ed_date_r     <= ed_date_nxt;
      ed_month_r    <= ed_month_nxt;
      ed_year_r     <= ed_year_nxt;
      ed_wday_r     <= ed_wday_nxt;
      clk_cur_r     <= clk_cur_nxt;
      week_cur_r    <= week_cur_nxt;
      day_cur_r     <= day_cur_nxt;
      wt_r          <= wt_nxt;
      marks_r       <= marks_nxt;
    end
  end

endmodule

FILE: hdl/weekly_time_switch_controller_core.sv
// Top level of the weekly time switch controller: input register, engine, result register.
// Depends on wtsc_pkg and wtsc_engine.
//
// Usage: each input item is a button press (in_kind = 0, in_button) or a clock sample
// (in_kind = 1, in_clock_*). Every accepted item yields exactly one result item on the
// out_ channel: relay drive, menu state, schedule mode, edit cursor and, when the clock
// editor is confirmed, out_clock_write with the edited time and date.
// Both channels use valid/ready; an item moves when valid and ready are high at a clock edge.
// The item is captured in the input register; the engine then updates its state from it and
// loads the result register at the same edge, once the result register is free.
// Throughput is one item per cycle while out_ready is high; the engine's single combinational
// pass from the input register to the result register sets that figure.
// When the receiver stalls, the result register holds its item and the input register holds
// one more; in_ready drops only while both are full.
// Reset (rst_n low, synchronous) empties both registers and returns the controller to idle,
// manual mode, relays off, all edit values and schedule settings zero.
module weekly_time_switch_controller_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [1:0] in_button,
  input  logic [4:0] in_clock_hour,
  input  logic [5:0] in_clock_minute,
  input  logic [5:0] in_clock_second,
  input  logic [4:0] in_clock_date,
  input  logic [3:0] in_clock_month,
  input  logic [6:0] in_clock_year,
  input  logic [2:0] in_clock_weekday,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_relay_bits,
  output logic [2:0] out_menu_state,
  output logic       out_week_mode,
  output logic [2:0] out_cursor_index,
  output logic       out_clock_write,
  output logic [4:0] out_set_hour,
  output logic [5:0] out_set_minute,
  output logic [5:0] out_set_second,
  output logic [4:0] out_set_date,
  output logic [3:0] out_set_month,
  output logic [6:0] out_set_year,
  output logic [2:0] out_set_weekday
);

  wtsc_pkg::item_t   item_r;
  wtsc_pkg::result_t res_r;
  wtsc_pkg::result_t res;
  logic              item_valid_r;
  logic              out_valid_r;
  logic              advance;

  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) item_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind    <= in_kind;
      item_r.button  <= in_button;
      item_r.hour    <= in_clock_hour;
      item_r.minute  <= in_clock_minute;
      item_r.second  <= in_clock_second;
      item_r.date    <= in_clock_date;
      item_r.month   <= in_clock_month;
      item_r.year    <= in_clock_year;
      item_r.weekday <= in_clock_weekday;
    end
    if (advance) res_r <= res;
  end

  wtsc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .res   (res)
  );

  assign out_valid        = out_valid_r;
  assign out_relay_bits   = res_r.relay_bits;
  assign out_menu_state   = res_r.menu_state;
  assign out_week_mode    = res_r.week_mode;
  assign out_cursor_index = res_r.cursor_index;
  assign out_clock_write  = res_r.clock_write;
  assign out_set_hour     = res_r.set_hour;
  assign out_set_minute   = res_r.set_minute;
  assign out_set_second   = res_r.set_second;
  assign out_set_date     = res_r.set_date;
  assign out_set_month    = res_r.set_month;
  assign out_set_year     = res_r.set_year;
  assign out_set_weekday  = res_r.set_weekday;

  // In schedule mode both relays always move together.
  a_week_relays_paired: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_week_mode) |-> (out_relay_bits == 2'b00 || out_relay_bits == 2'b11))
    else $error("relays differ in schedule mode");

  // Confirming the clock editor always returns to idle.
  a_write_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clock_write) |-> (out_menu_state == wtsc_pkg::CODE_IDLE))
    else $error("clock write outside idle");

  // Edited values appear only with a clock write.
  a_set_fields_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_clock_write) |->
      (out_set_hour == '0 && out_set_minute == '0 && out_set_second == '0 &&
       out_set_date == '0 && out_set_month == '0 && out_set_year == '0 &&
       out_set_weekday == '0))
    else $error("set fields nonzero without clock write");

  // A waiting result is never lost: an item in the input stage cannot advance over it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !advance)
    else $error("result register overwritten while stalled");

endmodule
